[hdl/first_substring_match_finder_core_assert.svh]
// assertion macros used by the checker file
`ifndef FIRST_SUBSTRING_MATCH_FINDER_CORE_ASSERT_SVH
`define FIRST_SUBSTRING_MATCH_FINDER_CORE_ASSERT_SVH

// same-cycle implication
`define FSMF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FSMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/fsmf_pkg.sv]
package fsmf_pkg;

   localparam int PATTERN_MAX_DEFAULT   = 16;
   localparam int POSITION_BITS_DEFAULT = 32;

   localparam int TEXT_BYTE_BITS      = 8;
   localparam int POSITION_OUT_BITS   = 32;
   localparam int LENGTH_BITS         = 5;
   localparam int PATTERN_STORE_BYTES = 16;
   localparam int STORE_IDX_BITS      = 4;
   localparam int PATTERN_WORD_BITS   = 64;
   localparam int CSR_DATA_BITS       = 64;
   localparam int CSR_INDEX_BITS      = 2;

   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = LENGTH_BITS'(1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LENGTH = 2'd0,
      CSR_PATTERN_LOW    = 2'd1,
      CSR_PATTERN_HIGH   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                         found;
      logic [POSITION_OUT_BITS-1:0] match_position;
   } rsp_payload_type;

endpackage

[hdl/fsmf_if.sv]
interface fsmf_req_if import fsmf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [TEXT_BYTE_BITS-1:0] text_byte;
   logic                      end_of_text;

   modport source (output valid, text_byte, end_of_text, input ready);
   modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface fsmf_rsp_if import fsmf_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [POSITION_OUT_BITS-1:0] match_position;

   modport source (output valid, found, match_position, input ready);
   modport sink   (input valid, found, match_position, output ready);
endinterface

[hdl/first_substring_match_finder_core.sv]
// Streaming first-match search of a configured pattern (1 to 16 bytes) in a text.
// req_chan carries one text byte per request plus end_of_text on the final byte.
// rsp_chan carries at most one response per text: found = 1 with the zero-based
// start offset of the first match, or found = 0 (offset 0) on the final byte when
// the text held no match. Bytes after a match produce nothing until the text ends.
// Configuration goes through csr_write_enable / csr_index / csr_write_data while
// the block is idle: index 0 pattern length, 1 pattern bytes 0-7, 2 bytes 8-15.
// Throughput: one request per cycle while the skid register is empty; the window
// compare is a single parallel equality check of the byte window against the pattern.
// A result is registered into the output register, or into the skid register if the output is stalled.
// The response side has an output register plus one skid register, so a stalled
// receiver holds the response and requests keep flowing until the skid register
// fills; req_chan.ready is then low until the receiver takes a response.
// Reset (synchronous, active high) clears the byte count and found flag, empties both
// response registers and sets pattern length 1 with an all-zero pattern.
// Byte offsets saturate at 2**POSITION_BITS - 1.
module first_substring_match_finder_core
   import fsmf_pkg::*;
#(
   parameter int PATTERN_MAX   = PATTERN_MAX_DEFAULT,
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   fsmf_req_if.sink                  req_chan,
   fsmf_rsp_if.source                rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int ALEN_BITS = $clog2(PATTERN_MAX + 1);
   localparam int CMP_BITS  = (ALEN_BITS > LENGTH_BITS) ? ALEN_BITS : LENGTH_BITS;
   localparam int PIDX_BITS = (ALEN_BITS > STORE_IDX_BITS + 1) ? ALEN_BITS
                                                               : STORE_IDX_BITS + 1;
   localparam logic [POSITION_BITS-1:0] SEEN_MAX = '1;

   // configuration
   logic [LENGTH_BITS-1:0]       length_ff;
   logic [PATTERN_WORD_BITS-1:0] pattern_low_ff;
   logic [PATTERN_WORD_BITS-1:0] pattern_high_ff;

   // search state
   logic [TEXT_BYTE_BITS-1:0] window_ff [PATTERN_MAX];
   logic [TEXT_BYTE_BITS-1:0] window_in [PATTERN_MAX];
   logic [POSITION_BITS-1:0]  seen_ff;
   logic [POSITION_BITS-1:0]  seen_in;
   logic                      found_ff;

   // response registers
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   logic            skid_valid_ff;
   rsp_payload_type skid_data_ff;

   logic [TEXT_BYTE_BITS-1:0] pattern_bytes [PATTERN_STORE_BYTES];
   logic [CMP_BITS-1:0]       length_ext;
   logic [ALEN_BITS-1:0]      active_len;
   logic [PATTERN_MAX-1:0]    lane_ok;
   logic                      accept;
   logic                      hit;
   logic                      has_result;
   logic                      push;
   logic                      pop;
   logic [POSITION_BITS-1:0]  start_pos;
   rsp_payload_type           result;

   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = out_valid_ff && rsp_chan.ready;

   assign req_chan.ready          = !skid_valid_ff;
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.found          = out_data_ff.found;
   assign rsp_chan.match_position = out_data_ff.match_position;

   always_comb begin
      for (int b = 0; b < PATTERN_STORE_BYTES / 2; b++) begin
         pattern_bytes[b] = pattern_low_ff[b*TEXT_BYTE_BITS +: TEXT_BYTE_BITS];
         pattern_bytes[b + PATTERN_STORE_BYTES / 2] =
            pattern_high_ff[b*TEXT_BYTE_BITS +: TEXT_BYTE_BITS];
      end
   end

   // length 0 counts as 1, longer than the window counts as the window
   always_comb begin
      length_ext = CMP_BITS'(length_ff);
      if (length_ext == '0) begin
         active_len = ALEN_BITS'(1);
      end else if (length_ext > CMP_BITS'(PATTERN_MAX)) begin
         active_len = ALEN_BITS'(PATTERN_MAX);
      end else begin
         active_len = ALEN_BITS'(length_ext);
      end
   end

   // newest byte at entry 0
   assign window_in[0] = req_chan.text_byte;
   for (genvar j = 1; j < PATTERN_MAX; j++) begin : g_shift
      assign window_in[j] = window_ff[j-1];
   end

   // window entry j lines up with pattern byte active_len - 1 - j
   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_lane
      logic [ALEN_BITS-1:0]      pidx;
      logic [PIDX_BITS-1:0]      pext;
      logic [TEXT_BYTE_BITS-1:0] pbyte;
      always_comb begin
         pidx = active_len - ALEN_BITS'(j) - ALEN_BITS'(1);
         pext = PIDX_BITS'(pidx);
         if (pext < PIDX_BITS'(PATTERN_STORE_BYTES)) begin
            pbyte = pattern_bytes[pext[STORE_IDX_BITS-1:0]];
         end else begin
            pbyte = '0;
         end
         lane_ok[j] = (ALEN_BITS'(j) >= active_len) || (window_in[j] == pbyte);
      end
   end

   assign seen_in    = (seen_ff == SEEN_MAX) ? seen_ff : seen_ff + POSITION_BITS'(1);
   assign hit        = !found_ff && (seen_in >= POSITION_BITS'(active_len)) && (&lane_ok);
   assign start_pos  = seen_in - POSITION_BITS'(active_len);
   assign has_result = hit || (req_chan.end_of_text && !found_ff);
   assign push       = accept && has_result;

   always_comb begin
      result.found          = hit;
      result.match_position = hit ? POSITION_OUT_BITS'(start_pos) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff       <= LENGTH_RESET;
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_LENGTH: length_ff       <= csr_write_data[LENGTH_BITS-1:0];
            CSR_PATTERN_LOW:    pattern_low_ff  <= csr_write_data;
            CSR_PATTERN_HIGH:   pattern_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // only entries written in the current text are ever compared
   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         found_ff <= 1'b0;
      end else if (accept) begin
         if (req_chan.end_of_text) begin
            seen_ff  <= '0;
            found_ff <= 1'b0;
         end else begin
            seen_ff  <= seen_in;
            found_ff <= found_ff || hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end
   end

endmodule

[hdl/fsmf_checker.sv]
`include "first_substring_match_finder_core_assert.svh"

module fsmf_checker
   import fsmf_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_found,
   input logic [POSITION_OUT_BITS-1:0] rsp_match_position
);

   // a stalled response keeps its payload
   `FSMF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_match_position), "response changed while stalled")

   // a not-found response carries offset zero
   `FSMF_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_found, rsp_match_position == '0, "not-found response with nonzero offset")

   // requests only back up behind a waiting response
   `FSMF_ASSERT_NOW(a_backpressure, clock, reset, !req_ready, rsp_valid, "request side stalled with no response pending")

   // reset empties the response side and opens the request side
   `FSMF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready, "response pending after reset")

   // a response only appears after an accepted request or a held one
   `FSMF_ASSERT_NEXT(a_no_invented, clock, reset, !rsp_valid && !(req_valid && req_ready), !rsp_valid, "response without a request")

endmodule

bind first_substring_match_finder_core fsmf_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_found          (rsp_chan.found),
   .rsp_match_position (rsp_chan.match_position)
);
